>>> src/cpwp_pkg.sv
package cpwp_pkg;

  localparam int unsigned PendDepth = 32;
  localparam int unsigned PendAw    = $clog2(PendDepth);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CfgDivider    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInitWord   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStartRef   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartWall  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPointTicks = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgKind       = 3'd5;

  localparam logic [1:0] FuncSample = 2'd0;
  localparam logic [1:0] FuncIssue  = 2'd1;
  localparam logic [1:0] FuncReturn = 2'd2;
  localparam logic [1:0] FuncFinish = 2'd3;

  localparam int unsigned SlopeW  = 20;
  localparam int unsigned CntW    = 24;
  localparam int unsigned DivNumW = 33;
  localparam int unsigned ProdW   = 52;

  localparam logic [CntW-1:0] LimitCap = 24'h800000;
  localparam logic [63:0]     StepMax  = 64'h0000_0000_0000_FFFF;
  localparam logic [31:0]     OffBias  = 32'd32768;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_START,
    OP_SET_SLOPE,
    OP_PUSH,
    OP_MARK,
    OP_RD,
    OP_FOLD_A,
    OP_FOLD_B,
    OP_FOLD_C,
    OP_FOLD_D,
    OP_CL_START,
    OP_CL_DR,
    OP_CL_E,
    OP_CL_SUM1,
    OP_CL_SUM2,
    OP_DRAIN_PT,
    OP_NEWWORD,
    OP_PK_A,
    OP_PK_B,
    OP_PK_ADD,
    OP_PK_NEW,
    OP_EMIT,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e  op;
    logic close;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       word_eq;
    logic       cnt_nz;
    logic       conf_go;
    logic       drain_go;
    logic       fold_close;
    logic       div_busy;
    logic       points_zero;
    logic       points_two;
    logic       pk_ok;
    logic       hold_v;
    logic       can_push;
  } stat_t;

  typedef struct packed {
    logic [31:0] meta;
    logic [31:0] round_word;
    logic [63:0] point_refclk;
    logic [63:0] point_wall8;
    logic [31:0] step_one;
    logic [31:0] step_two;
  } rec_t;

endpackage

>>> src/cpwp_item_if.sv
interface cpwp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] sample_refclk;
  logic [31:0] sample_wall8;
  logic [31:0] pll_word;

  modport source (output valid, func, sample_refclk, sample_wall8, pll_word, input ready);
  modport sink (input valid, func, sample_refclk, sample_wall8, pll_word, output ready);
endinterface

>>> src/cpwp_rec_if.sv
interface cpwp_rec_if;
  logic        valid;
  logic        ready;
  logic [31:0] meta;
  logic [31:0] round_word;
  logic [63:0] point_refclk;
  logic [63:0] point_wall8;
  logic [31:0] step_one;
  logic [31:0] step_two;
  logic        last_of_run;

  modport source (output valid, meta, round_word, point_refclk, point_wall8, step_one,
                  step_two, last_of_run, input ready);
  modport sink (input valid, meta, round_word, point_refclk, point_wall8, step_one,
                step_two, last_of_run, output ready);
endinterface

>>> src/cpwp_div.sv
// Restoring divider, one quotient bit per cycle.
module cpwp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cpwp_pkg::DivNumW-1:0] num_i,
  input  logic [cpwp_pkg::CntW-1:0]    den_i,
  output logic                         busy_o,
  output logic [cpwp_pkg::DivNumW-1:0] quo_o
);

  logic [5:0]                   cnt_q;
  logic [cpwp_pkg::CntW-1:0]    rem_q, den_q, rem_d;
  logic [cpwp_pkg::DivNumW-1:0] quo_q;
  logic [cpwp_pkg::CntW:0]      shifted, diff;
  logic                         ge;

  assign shifted = {rem_q, quo_q[cpwp_pkg::DivNumW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};
  assign rem_d   = ge ? diff[cpwp_pkg::CntW-1:0] : shifted[cpwp_pkg::CntW-1:0];
  assign busy_o  = cnt_q != 6'd0;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (start_i) begin
      cnt_q <= 6'(cpwp_pkg::DivNumW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[cpwp_pkg::DivNumW-2:0], ge};
    end
  end

endmodule

>>> src/cpwp_dp.sv
// Datapath: configuration, window accumulators, pending sample store,
// record packing and the output staging registers.
module cpwp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpwp_pkg::cmd_t                cmd_i,
  output cpwp_pkg::stat_t               st_o,
  input  logic                          cfg_we_i,
  input  logic [cpwp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpwp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [1:0]                    func_i,
  input  logic [31:0]                   sample_refclk_i,
  input  logic [31:0]                   sample_wall8_i,
  input  logic [31:0]                   pll_word_i,
  input  logic                          rec_ready_i,
  output logic                          rec_valid_o,
  output cpwp_pkg::rec_t                rec_o,
  output logic                          last_o
);

  function automatic logic [63:0] widen(input logic [63:0] base, input logic [31:0] lo);
    logic [31:0] d;
    begin
      d     = lo - base[31:0];
      widen = base + {{32{d[31]}}, d};
    end
  endfunction

  // Configuration registers.
  logic [3:0]  div_prod_q;
  logic [31:0] init_word_q, pt_ticks_q;
  logic [63:0] start_ref_q, start_wall_q;
  logic [7:0]  kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_prod_q   <= 4'd8;
      init_word_q  <= '0;
      start_ref_q  <= '0;
      start_wall_q <= '0;
      pt_ticks_q   <= 32'd50000;
      kind_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpwp_pkg::CfgDivider:    div_prod_q   <= cfg_data_i[3:0];
        cpwp_pkg::CfgInitWord:   init_word_q  <= cfg_data_i[31:0];
        cpwp_pkg::CfgStartRef:   start_ref_q  <= cfg_data_i;
        cpwp_pkg::CfgStartWall:  start_wall_q <= cfg_data_i;
        cpwp_pkg::CfgPointTicks: pt_ticks_q   <= cfg_data_i[31:0];
        cpwp_pkg::CfgKind:       kind_q       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Latched item.
  logic [1:0]  func_q;
  logic [31:0] in_ref_q, in_wall_q, word_q;

  // Window and sample bookkeeping.
  logic [31:0]                 cur_word_q;
  logic [cpwp_pkg::SlopeW-1:0] slope_q;
  logic [63:0]                 anchor_ref_q, anchor_wall_q;
  logic [31:0]                 ref_sum_q, res_sum_q;
  logic [cpwp_pkg::CntW-1:0]   cnt_q, lim_q, cnt_sv_q;
  logic [31:0]                 pushed_q, done_q, mark_q;

  // Work registers.
  logic [31:0]                 dr_q;
  logic [cpwp_pkg::ProdW-1:0]  prod_q;
  logic                        close_q, e_neg_q, pt_close_q, pk_fit_q;
  logic [63:0]                 e_q, pt_r_q, pt_w_q;
  logic [cpwp_pkg::SlopeW-1:0] pt_k_q;
  logic [15:0]                 pk_dr_q;

  // Record being built, held record and output register.
  logic [1:0]     points_q;
  logic [31:0]    rmeta_q, rround_q, rs0_q, rs1_q;
  logic [63:0]    rref_q, rwall_q;
  cpwp_pkg::rec_t hold_q, out_q, snap;
  logic           hold_v_q, out_v_q, out_last_q;

  // Pending sample store.
  logic [31:0] mem_ref [cpwp_pkg::PendDepth];
  logic [31:0] mem_wall [cpwp_pkg::PendDepth];
  logic [31:0] rd_ref_q, rd_wall_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cpwp_pkg::OP_PUSH) begin
      mem_ref[pushed_q[cpwp_pkg::PendAw-1:0]]  <= in_ref_q;
      mem_wall[pushed_q[cpwp_pkg::PendAw-1:0]] <= in_wall_q;
    end
    if (cmd_i.op == cpwp_pkg::OP_RD) begin
      rd_ref_q  <= mem_ref[done_q[cpwp_pkg::PendAw-1:0]];
      rd_wall_q <= mem_wall[done_q[cpwp_pkg::PendAw-1:0]];
    end
  end

  // Shared divider.
  logic                         div_start, div_busy;
  logic [cpwp_pkg::DivNumW-1:0] div_num, div_quo;
  logic [cpwp_pkg::CntW-1:0]    div_den;
  logic [31:0]                  slope_word;
  logic [3:0]                   den_fix;
  logic [33:0]                  se34, half34, nums, mag34;

  assign slope_word = (cmd_i.op == cpwp_pkg::OP_START) ? init_word_q : word_q;
  assign den_fix    = (div_prod_q == 4'd0) ? 4'd1 : div_prod_q;
  assign se34       = {{2{res_sum_q[31]}}, res_sum_q};
  assign half34     = {11'd0, cnt_sv_q[cpwp_pkg::CntW-1:1]};
  assign nums       = res_sum_q[31] ? (se34 - half34) : (se34 + half34);
  assign mag34      = res_sum_q[31] ? (34'd0 - nums) : nums;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i.op)
      cpwp_pkg::OP_START, cpwp_pkg::OP_NEWWORD: begin
        div_start = 1'b1;
        div_num   = {14'd0, slope_word[31:16], 3'd0};
        div_den   = {20'd0, den_fix};
      end
      cpwp_pkg::OP_CL_START: begin
        div_start = 1'b1;
        div_num   = {1'b0, ref_sum_q + {9'd0, cnt_q[cpwp_pkg::CntW-1:1]}};
        div_den   = cnt_q;
      end
      cpwp_pkg::OP_CL_DR: begin
        div_start = 1'b1;
        div_num   = mag34[cpwp_pkg::DivNumW-1:0];
        div_den   = cnt_sv_q;
      end
      default: ;
    endcase
  end

  cpwp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Shared multiplier, registered.
  logic [31:0]                 mul_a;
  logic [cpwp_pkg::SlopeW-1:0] mul_b;
  always_comb begin
    if (cmd_i.op == cpwp_pkg::OP_PK_B) begin
      mul_a = {16'd0, pk_dr_q};
      mul_b = {12'd0, rround_q[31:24]};
    end else begin
      mul_a = dr_q;
      mul_b = slope_q;
    end
  end

  // Packing checks.
  logic [63:0] pk_diff;
  logic [31:0] off, offb, step_word;
  logic        pk_ok;
  assign pk_diff   = pt_r_q - rref_q;
  assign off       = pt_w_q[31:0] - rwall_q[31:0] - prod_q[31:0];
  assign offb      = off + cpwp_pkg::OffBias;
  assign pk_ok     = pk_fit_q && (offb[31:16] == 16'd0);
  assign step_word = {off[15:0], pk_dr_q};

  logic [31:0] gap;
  logic        can_push;
  logic        out_v_d;
  assign gap      = mark_q - done_q;
  assign can_push = !out_v_q || rec_ready_i;

  // The output register empties when taken and fills when a record moves in.
  always_comb begin
    out_v_d = out_v_q && !rec_ready_i;
    if ((cmd_i.op == cpwp_pkg::OP_EMIT && hold_v_q) || cmd_i.op == cpwp_pkg::OP_FIN) begin
      out_v_d = 1'b1;
    end
  end

  always_comb begin
    snap              = '0;
    snap.meta         = rmeta_q | {30'd0, points_q};
    snap.round_word   = rround_q;
    snap.point_refclk = rref_q;
    snap.point_wall8  = rwall_q;
    snap.step_one     = rs0_q;
    snap.step_two     = rs1_q;
  end

  // Control-like state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      lim_q    <= {{(cpwp_pkg::CntW-1){1'b0}}, 1'b1};
      pushed_q <= '0;
      done_q   <= '0;
      mark_q   <= '0;
      points_q <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      case (cmd_i.op)
        cpwp_pkg::OP_PUSH: begin
          if ((pushed_q - done_q) >= 32'(cpwp_pkg::PendDepth)) begin
            done_q <= pushed_q - 32'(cpwp_pkg::PendDepth - 1);
          end
          pushed_q <= pushed_q + 32'd1;
        end
        cpwp_pkg::OP_MARK: mark_q <= pushed_q;
        cpwp_pkg::OP_FOLD_A, cpwp_pkg::OP_DRAIN_PT: done_q <= done_q + 32'd1;
        cpwp_pkg::OP_FOLD_D: cnt_q <= cnt_q + 1'b1;
        cpwp_pkg::OP_CL_START: begin
          cnt_q <= '0;
          if (lim_q < cpwp_pkg::LimitCap) begin
            lim_q <= {lim_q[cpwp_pkg::CntW-2:0], 1'b0};
          end
        end
        cpwp_pkg::OP_NEWWORD: lim_q <= {{(cpwp_pkg::CntW-1){1'b0}}, 1'b1};
        cpwp_pkg::OP_PK_ADD: points_q <= points_q + 2'd1;
        cpwp_pkg::OP_PK_NEW: points_q <= 2'd1;
        cpwp_pkg::OP_EMIT: begin
          points_q <= '0;
          hold_v_q <= 1'b1;
        end
        cpwp_pkg::OP_FIN: hold_v_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cpwp_pkg::OP_ACCEPT: begin
        func_q    <= func_i;
        in_ref_q  <= sample_refclk_i;
        in_wall_q <= sample_wall8_i;
        word_q    <= pll_word_i;
      end
      cpwp_pkg::OP_START: begin
        cur_word_q    <= init_word_q;
        anchor_ref_q  <= start_ref_q;
        anchor_wall_q <= start_wall_q;
      end
      cpwp_pkg::OP_SET_SLOPE: slope_q <= div_quo[cpwp_pkg::SlopeW-1:0];
      cpwp_pkg::OP_FOLD_A: begin
        if (cnt_q == '0) begin
          anchor_ref_q  <= widen(anchor_ref_q, rd_ref_q);
          anchor_wall_q <= widen(anchor_wall_q, rd_wall_q);
          ref_sum_q     <= '0;
          res_sum_q     <= '0;
        end
      end
      cpwp_pkg::OP_FOLD_B: dr_q <= rd_ref_q - anchor_ref_q[31:0];
      cpwp_pkg::OP_FOLD_C: prod_q <= mul_a * mul_b;
      cpwp_pkg::OP_FOLD_D: begin
        ref_sum_q <= ref_sum_q + dr_q;
        res_sum_q <= res_sum_q + rd_wall_q - anchor_wall_q[31:0] - prod_q[31:0];
      end
      cpwp_pkg::OP_CL_START: begin
        cnt_sv_q <= cnt_q;
        close_q  <= cmd_i.close;
      end
      cpwp_pkg::OP_CL_DR: begin
        dr_q    <= div_quo[31:0];
        e_neg_q <= res_sum_q[31];
      end
      cpwp_pkg::OP_CL_E: begin
        e_q    <= e_neg_q ? (64'd0 - {31'd0, div_quo}) : {31'd0, div_quo};
        prod_q <= mul_a * mul_b;
      end
      cpwp_pkg::OP_CL_SUM1: begin
        pt_r_q     <= anchor_ref_q + {32'd0, dr_q};
        pt_w_q     <= anchor_wall_q + {12'd0, prod_q};
        pt_k_q     <= slope_q;
        pt_close_q <= close_q;
      end
      cpwp_pkg::OP_CL_SUM2: pt_w_q <= pt_w_q + e_q;
      cpwp_pkg::OP_DRAIN_PT: begin
        pt_r_q     <= widen(anchor_ref_q, rd_ref_q);
        pt_w_q     <= widen(anchor_wall_q, rd_wall_q);
        pt_k_q     <= '0;
        pt_close_q <= 1'b0;
      end
      cpwp_pkg::OP_NEWWORD: cur_word_q <= word_q;
      cpwp_pkg::OP_PK_A: begin
        pk_fit_q <= pk_diff <= cpwp_pkg::StepMax;
        pk_dr_q  <= pk_diff[15:0];
      end
      cpwp_pkg::OP_PK_B: prod_q <= mul_a * mul_b;
      cpwp_pkg::OP_PK_ADD: begin
        if (points_q == 2'd1) begin
          rs0_q <= step_word;
        end else begin
          rs1_q <= step_word;
        end
        rround_q <= rround_q | ({12'd0, pt_k_q} << {points_q, 3'b000});
        rmeta_q  <= rmeta_q | ({31'd0, pt_close_q} << (5'd2 + {3'd0, points_q}));
      end
      cpwp_pkg::OP_PK_NEW: begin
        rref_q   <= pt_r_q;
        rwall_q  <= pt_w_q;
        rround_q <= {12'd0, pt_k_q} | {slope_q[7:0], 24'd0};
        rmeta_q  <= {16'd0, kind_q, 5'd0, pt_close_q, 2'd0};
        rs0_q    <= '0;
        rs1_q    <= '0;
      end
      cpwp_pkg::OP_EMIT: begin
        hold_q <= snap;
        if (hold_v_q) begin
          out_q      <= hold_q;
          out_last_q <= 1'b0;
        end
      end
      cpwp_pkg::OP_FIN: begin
        out_q      <= hold_q;
        out_last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign rec_valid_o = out_v_q;
  assign rec_o       = out_q;
  assign last_o      = out_last_q;

  always_comb begin
    st_o             = '0;
    st_o.func        = func_q;
    st_o.word_eq     = word_q == cur_word_q;
    st_o.cnt_nz      = cnt_q != '0;
    st_o.conf_go     = (done_q != pushed_q) && (gap != 32'd0) && !gap[31];
    st_o.drain_go    = done_q != pushed_q;
    st_o.fold_close  = ((cnt_q + 1'b1) == lim_q) || (dr_q >= pt_ticks_q);
    st_o.div_busy    = div_busy;
    st_o.points_zero = points_q == 2'd0;
    st_o.points_two  = points_q == 2'd2;
    st_o.pk_ok       = pk_ok;
    st_o.hold_v      = hold_v_q;
    st_o.can_push    = can_push;
  end

endmodule

>>> src/cpwp_ctrl.sv
// Sequencer: walks each item through push, confirm, fold, close, pack and
// emit steps, with return points for the close, pack and emit sequences.
module cpwp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cpwp_pkg::stat_t st_i,
  output cpwp_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_START_WAIT, S_DISPATCH, S_CONF_CHECK, S_CONF_RD, S_FOLD_B,
    S_FOLD_C, S_FOLD_D, S_CL_START, S_CL_W1, S_CL_W2, S_CL_SUM1, S_CL_SUM2,
    S_DRAIN_CHECK, S_DRAIN_RD, S_NW_WAIT, S_PACK, S_PK_B, S_PK_C, S_PK_NEW,
    S_EMIT, S_FLUSH, S_FINISH
  } state_e;

  state_e state_q, state_d, close_ret_q, close_ret_d, pack_ret_q, pack_ret_d;
  state_e emit_ret_q, emit_ret_d;
  logic   started_q, started_d, cflag_q, cflag_d;

  always_comb begin
    state_d     = state_q;
    close_ret_d = close_ret_q;
    pack_ret_d  = pack_ret_q;
    emit_ret_d  = emit_ret_q;
    started_d   = started_q;
    cflag_d     = cflag_q;
    ready_o     = 1'b0;
    cmd_o.op    = cpwp_pkg::OP_NONE;
    cmd_o.close = cflag_q;
    unique case (state_q)
      S_IDLE: begin
        ready_o = 1'b1;
        if (valid_i) begin
          cmd_o.op  = cpwp_pkg::OP_ACCEPT;
          started_d = 1'b1;
          state_d   = started_q ? S_DISPATCH : S_START;
        end
      end
      S_START: begin
        cmd_o.op = cpwp_pkg::OP_START;
        state_d  = S_START_WAIT;
      end
      S_START_WAIT: begin
        if (!st_i.div_busy) begin
          cmd_o.op = cpwp_pkg::OP_SET_SLOPE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st_i.func)
          cpwp_pkg::FuncSample: begin
            cmd_o.op = cpwp_pkg::OP_PUSH;
            state_d  = S_FINISH;
          end
          cpwp_pkg::FuncIssue: begin
            cmd_o.op = cpwp_pkg::OP_MARK;
            state_d  = S_FINISH;
          end
          cpwp_pkg::FuncReturn: begin
            if (st_i.word_eq) begin
              state_d = S_CONF_CHECK;
            end else if (st_i.cnt_nz) begin
              cflag_d     = 1'b1;
              close_ret_d = S_DRAIN_CHECK;
              state_d     = S_CL_START;
            end else begin
              state_d = S_DRAIN_CHECK;
            end
          end
          default: begin
            if (st_i.cnt_nz) begin
              cflag_d     = 1'b0;
              close_ret_d = S_FLUSH;
              state_d     = S_CL_START;
            end else begin
              state_d = S_FLUSH;
            end
          end
        endcase
      end
      S_CONF_CHECK: begin
        if (st_i.conf_go) begin
          cmd_o.op = cpwp_pkg::OP_RD;
          state_d  = S_CONF_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_CONF_RD: begin
        cmd_o.op = cpwp_pkg::OP_FOLD_A;
        state_d  = S_FOLD_B;
      end
      S_FOLD_B: begin
        cmd_o.op = cpwp_pkg::OP_FOLD_B;
        state_d  = S_FOLD_C;
      end
      S_FOLD_C: begin
        cmd_o.op = cpwp_pkg::OP_FOLD_C;
        state_d  = S_FOLD_D;
      end
      S_FOLD_D: begin
        cmd_o.op = cpwp_pkg::OP_FOLD_D;
        if (st_i.fold_close) begin
          cflag_d     = 1'b0;
          close_ret_d = S_CONF_CHECK;
          state_d     = S_CL_START;
        end else begin
          state_d = S_CONF_CHECK;
        end
      end
      S_CL_START: begin
        cmd_o.op = cpwp_pkg::OP_CL_START;
        state_d  = S_CL_W1;
      end
      S_CL_W1: begin
        if (!st_i.div_busy) begin
          cmd_o.op = cpwp_pkg::OP_CL_DR;
          state_d  = S_CL_W2;
        end
      end
      S_CL_W2: begin
        if (!st_i.div_busy) begin
          cmd_o.op = cpwp_pkg::OP_CL_E;
          state_d  = S_CL_SUM1;
        end
      end
      S_CL_SUM1: begin
        cmd_o.op = cpwp_pkg::OP_CL_SUM1;
        state_d  = S_CL_SUM2;
      end
      S_CL_SUM2: begin
        cmd_o.op   = cpwp_pkg::OP_CL_SUM2;
        pack_ret_d = close_ret_q;
        state_d    = S_PACK;
      end
      S_DRAIN_CHECK: begin
        if (st_i.drain_go) begin
          cmd_o.op = cpwp_pkg::OP_RD;
          state_d  = S_DRAIN_RD;
        end else begin
          cmd_o.op = cpwp_pkg::OP_NEWWORD;
          state_d  = S_NW_WAIT;
        end
      end
      S_DRAIN_RD: begin
        cmd_o.op   = cpwp_pkg::OP_DRAIN_PT;
        pack_ret_d = S_DRAIN_CHECK;
        state_d    = S_PACK;
      end
      S_NW_WAIT: begin
        if (!st_i.div_busy) begin
          cmd_o.op = cpwp_pkg::OP_SET_SLOPE;
          state_d  = S_FINISH;
        end
      end
      S_PACK: begin
        if (st_i.points_zero) begin
          state_d = S_PK_NEW;
        end else begin
          cmd_o.op = cpwp_pkg::OP_PK_A;
          state_d  = S_PK_B;
        end
      end
      S_PK_B: begin
        cmd_o.op = cpwp_pkg::OP_PK_B;
        state_d  = S_PK_C;
      end
      S_PK_C: begin
        if (st_i.pk_ok) begin
          cmd_o.op = cpwp_pkg::OP_PK_ADD;
          if (st_i.points_two) begin
            emit_ret_d = pack_ret_q;
            state_d    = S_EMIT;
          end else begin
            state_d = pack_ret_q;
          end
        end else begin
          emit_ret_d = S_PK_NEW;
          state_d    = S_EMIT;
        end
      end
      S_PK_NEW: begin
        cmd_o.op = cpwp_pkg::OP_PK_NEW;
        state_d  = pack_ret_q;
      end
      S_EMIT: begin
        if (st_i.points_zero) begin
          state_d = emit_ret_q;
        end else if (!st_i.hold_v || st_i.can_push) begin
          cmd_o.op = cpwp_pkg::OP_EMIT;
          state_d  = emit_ret_q;
        end
      end
      S_FLUSH: begin
        emit_ret_d = S_FINISH;
        state_d    = S_EMIT;
      end
      S_FINISH: begin
        if (!st_i.hold_v) begin
          state_d = S_IDLE;
        end else if (st_i.can_push) begin
          cmd_o.op = cpwp_pkg::OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      close_ret_q <= S_IDLE;
      pack_ret_q  <= S_IDLE;
      emit_ret_q  <= S_IDLE;
      started_q   <= 1'b0;
      cflag_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      close_ret_q <= close_ret_d;
      pack_ret_q  <= pack_ret_d;
      emit_ret_q  <= emit_ret_d;
      started_q   <= started_d;
      cflag_q     <= cflag_d;
    end
  end

endmodule

>>> src/clock_point_window_packer.sv
// Clock point window packer. Items carry wall-clock versus reference-clock
// samples, PLL read-issue and read-return events, and a finish command. Samples
// wait in a 32-entry pending store until a read issued after them returns the
// multiplier in force; confirmed samples are folded into doubling windows whose
// rounded centroids become points, and points are packed up to three per
// record on the rec_o channel, with last_of_run set on the final record of an
// item. Items are taken one at a time. The first item after reset also divides
// to derive the slope. A read return folds each sample it confirms, and each
// closed window takes two passes of the shared bit-serial divider before its
// point is packed. A changed multiplier closes the open window if it holds
// samples, drains each pending sample as a point with its packing, and divides
// anew for the slope. Records leave through a hold register and an output
// register, so the next item is accepted while a record still waits; the
// sequencer stalls whenever a record must move from the hold register into an
// output register that the consumer has not yet taken. Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must do this
// only while the block is idle, which the block itself does not enforce. The
// start values are latched at the first item after reset.
module clock_point_window_packer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cpwp_item_if.sink                     item_i,
  cpwp_rec_if.source                    rec_o,
  input  logic                          cfg_we_i,
  input  logic [cpwp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpwp_pkg::CfgDataW-1:0] cfg_data_i
);

  cpwp_pkg::cmd_t  cmd;
  cpwp_pkg::stat_t st;
  cpwp_pkg::rec_t  rec;
  logic            rec_valid, rec_last;

  // The sequencer owns the input handshake.
  cpwp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(item_i.valid),
    .ready_o(item_i.ready),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  // The datapath latches the item on accept and drives the output register.
  cpwp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (item_i.func),
    .sample_refclk_i(item_i.sample_refclk),
    .sample_wall8_i (item_i.sample_wall8),
    .pll_word_i     (item_i.pll_word),
    .rec_ready_i    (rec_o.ready),
    .rec_valid_o    (rec_valid),
    .rec_o          (rec),
    .last_o         (rec_last)
  );

  assign rec_o.valid        = rec_valid;
  assign rec_o.meta         = rec.meta;
  assign rec_o.round_word   = rec.round_word;
  assign rec_o.point_refclk = rec.point_refclk;
  assign rec_o.point_wall8  = rec.point_wall8;
  assign rec_o.step_one     = rec.step_one;
  assign rec_o.step_two     = rec.step_two;
  assign rec_o.last_of_run  = rec_last;

  // The hold register is always drained before a new item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) item_i.ready |-> !st.hold_v)
    else $error("item accepted with a record still held");

  // The divider is never restarted while a division is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == cpwp_pkg::OP_START || cmd.op == cpwp_pkg::OP_NEWWORD ||
     cmd.op == cpwp_pkg::OP_CL_START || cmd.op == cpwp_pkg::OP_CL_DR) |-> !st.div_busy)
    else $error("divider started while busy");

  // Items are processed one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("ready stayed high after an accept");

  // A record only goes out once the output register is free or being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == cpwp_pkg::OP_FIN) |-> st.can_push)
    else $error("final record pushed into a full output register");

endmodule
